/* hdl/assert_macros.svh */
// assertion helpers; expect clk and rst in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rbl_pkg.sv */
`default_nettype none
package rbl_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int HANDLE_W    = 32;
  localparam int SIZE_W      = 16;
  localparam int OFFSET_W    = 20;
  localparam int SLOT_W      = 4;
  localparam int TOTAL_W     = 20;
  localparam int REC_W       = HANDLE_W + SIZE_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_LK_RD,
    ST_LK_CHK
  } state_t;

endpackage
`default_nettype wire

/* hdl/ring_buffer_byte_offset_lookup.sv */
// Add: reads the slot to be overwritten (ADD_RD), writes it (ADD_WR), then strobes done.
// Lookup: reads the oldest record (LK_RD), then walks 1..ENTRIES records in LK_CHK until a hit or the last,
// one stored record per cycle through the single record-memory read port; an
// empty ring answers from LK_RD. A new start is taken in the done cycle.
// Reset (synchronous rst) clears positions, count and total; stores are not cleared.
`default_nettype none
`include "assert_macros.svh"
module ring_buffer_byte_offset_lookup #(
  parameter int ENTRIES = rbl_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          op,
  input  wire logic [rbl_pkg::HANDLE_W-1:0]  record_handle,
  input  wire logic [rbl_pkg::SIZE_W-1:0]    record_size,
  input  wire logic [rbl_pkg::OFFSET_W-1:0]  byte_offset,
  output      logic                          done,
  output      logic                          found,
  output      logic [rbl_pkg::SLOT_W-1:0]    slot_index,
  output      logic [rbl_pkg::HANDLE_W-1:0]  hit_handle,
  output      logic [rbl_pkg::SIZE_W-1:0]    hit_size,
  output      logic [rbl_pkg::SIZE_W-1:0]    byte_in_record,
  output      logic                          evicted,
  output      logic [rbl_pkg::HANDLE_W-1:0]  evicted_handle,
  output      logic [rbl_pkg::TOTAL_W-1:0]   total_bytes
);

  localparam int PW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int EXACT_W = $clog2(ENTRIES * 65535 + 1);
  localparam int SUM_W  = (EXACT_W > rbl_pkg::OFFSET_W) ? EXACT_W : rbl_pkg::OFFSET_W;
  localparam int EXT_W  = (PW > rbl_pkg::SLOT_W) ? PW : rbl_pkg::SLOT_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(ENTRIES - 1);

  rbl_pkg::state_t state, state_next;

  logic [PW-1:0]                   wr_pos;
  logic [PW-1:0]                   rd_pos;
  logic [CW-1:0]                   count;
  logic [SUM_W-1:0]                byte_total;
  logic [PW-1:0]                   idx;
  logic [CW-1:0]                   rem;
  logic [SUM_W-1:0]                sum;
  logic [rbl_pkg::HANDLE_W-1:0]    req_handle;
  logic [rbl_pkg::SIZE_W-1:0]      req_size;
  logic [rbl_pkg::OFFSET_W-1:0]    req_offset;

  logic                            mem_wr_en;
  logic                            mem_rd_en;
  logic [PW-1:0]                   mem_rd_addr;
  logic [rbl_pkg::REC_W-1:0]       mem_rd_data;

  logic                            full;
  logic [rbl_pkg::SIZE_W-1:0]      rd_size;
  logic [rbl_pkg::HANDLE_W-1:0]    rd_handle;
  logic [SUM_W-1:0]                sum_plus;
  logic                            hit;
  logic [SUM_W-1:0]                in_rec;
  logic [SUM_W-1:0]                add_total;
  logic [rbl_pkg::TOTAL_W-1:0]     add_total_sat;
  logic [rbl_pkg::TOTAL_W-1:0]     cur_total_sat;
  logic [PW-1:0]                   wr_pos_next;
  logic [PW-1:0]                   rd_pos_next;
  logic [PW-1:0]                   idx_next;
  logic [EXT_W-1:0]                wr_slot_ext;
  logic [EXT_W-1:0]                idx_slot_ext;

  rbl_mem #(
    .ENTRIES (ENTRIES),
    .AW      (PW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_pos),
    .wr_data ({req_handle, req_size}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign full          = (count == CW'(ENTRIES));
  assign rd_size       = mem_rd_data[rbl_pkg::SIZE_W-1:0];
  assign rd_handle     = mem_rd_data[rbl_pkg::REC_W-1:rbl_pkg::SIZE_W];
  assign sum_plus      = sum + SUM_W'(rd_size);
  assign hit           = (sum_plus > SUM_W'(req_offset));
  assign in_rec        = SUM_W'(req_offset) - sum;
  assign add_total     = byte_total - (full ? SUM_W'(rd_size) : '0) + SUM_W'(req_size);
  assign add_total_sat = (add_total > SUM_W'(rbl_pkg::TOTAL_MAX)) ?
                         rbl_pkg::TOTAL_MAX : add_total[rbl_pkg::TOTAL_W-1:0];
  assign cur_total_sat = (byte_total > SUM_W'(rbl_pkg::TOTAL_MAX)) ?
                         rbl_pkg::TOTAL_MAX : byte_total[rbl_pkg::TOTAL_W-1:0];
  assign wr_pos_next   = (wr_pos == LAST_SLOT) ? '0 : wr_pos + PW'(1);
  assign rd_pos_next   = (rd_pos == LAST_SLOT) ? '0 : rd_pos + PW'(1);
  assign idx_next      = (idx == LAST_SLOT) ? '0 : idx + PW'(1);
  assign wr_slot_ext   = EXT_W'(wr_pos);
  assign idx_slot_ext  = EXT_W'(idx);

  always_comb begin
    state_next = state;
    case (state)
      rbl_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (op == rbl_pkg::OP_ADD) ? rbl_pkg::ST_ADD_RD : rbl_pkg::ST_LK_RD;
        end
      end
      rbl_pkg::ST_ADD_RD: state_next = rbl_pkg::ST_ADD_WR;
      rbl_pkg::ST_ADD_WR: state_next = rbl_pkg::ST_IDLE;
      rbl_pkg::ST_LK_RD: begin
        state_next = (count == '0) ? rbl_pkg::ST_IDLE : rbl_pkg::ST_LK_CHK;
      end
      rbl_pkg::ST_LK_CHK: begin
        if (hit || rem == CW'(1)) begin
          state_next = rbl_pkg::ST_IDLE;
        end
      end
      default: state_next = rbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_next;
    case (state)
      rbl_pkg::ST_IDLE: busy = 1'b0;
      rbl_pkg::ST_ADD_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = wr_pos;
      end
      rbl_pkg::ST_ADD_WR: mem_wr_en = 1'b1;
      rbl_pkg::ST_LK_RD: begin
        mem_rd_en   = (count != '0);
        mem_rd_addr = rd_pos;
      end
      rbl_pkg::ST_LK_CHK: mem_rd_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rbl_pkg::ST_IDLE;
      wr_pos     <= '0;
      rd_pos     <= '0;
      count      <= '0;
      byte_total <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        rbl_pkg::ST_ADD_WR: begin
          byte_total <= add_total;
          wr_pos     <= wr_pos_next;
          if (full) begin
            rd_pos <= rd_pos_next;
          end else begin
            count <= count + CW'(1);
          end
          done <= 1'b1;
        end
        rbl_pkg::ST_LK_RD: begin
          if (count == '0) begin
            done <= 1'b1;
          end
        end
        rbl_pkg::ST_LK_CHK: begin
          if (hit || rem == CW'(1)) begin
            done <= 1'b1;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rbl_pkg::ST_IDLE: begin
        if (start) begin
          req_handle <= record_handle;
          req_size   <= record_size;
          req_offset <= byte_offset;
        end
      end
      rbl_pkg::ST_ADD_WR: begin
        found          <= 1'b0;
        slot_index     <= wr_slot_ext[rbl_pkg::SLOT_W-1:0];
        hit_handle     <= '0;
        hit_size       <= '0;
        byte_in_record <= '0;
        evicted        <= full;
        evicted_handle <= full ? rd_handle : '0;
        total_bytes    <= add_total_sat;
      end
      rbl_pkg::ST_LK_RD: begin
        idx            <= rd_pos;
        rem            <= count;
        sum            <= '0;
        found          <= 1'b0;
        slot_index     <= '0;
        hit_handle     <= '0;
        hit_size       <= '0;
        byte_in_record <= '0;
        evicted        <= 1'b0;
        evicted_handle <= '0;
        total_bytes    <= cur_total_sat;
      end
      rbl_pkg::ST_LK_CHK: begin
        if (hit) begin
          found          <= 1'b1;
          slot_index     <= idx_slot_ext[rbl_pkg::SLOT_W-1:0];
          hit_handle     <= rd_handle;
          hit_size       <= rd_size;
          byte_in_record <= in_rec[rbl_pkg::SIZE_W-1:0];
        end else begin
          sum <= sum_plus;
          idx <= idx_next;
          rem <= rem - CW'(1);
        end
      end
      default: begin
        sum <= sum;
      end
    endcase
  end

  `RBL_ASSERT(a_done_idle, done |-> (state == rbl_pkg::ST_IDLE), "done outside idle")
  `RBL_ASSERT(a_count_range, count <= CW'(ENTRIES), "record count above depth")
  `RBL_ASSERT(a_full_aligned, full |-> (wr_pos == rd_pos), "full ring with split positions")
  `RBL_ASSERT(a_evict_full, (done && evicted) |-> full, "eviction without full ring")
  `RBL_ASSERT(a_hit_inside, (done && found) |-> (byte_in_record < hit_size), "hit past record end")

endmodule
`default_nettype wire

/* hdl/rbl_mem.sv */
`default_nettype none
module rbl_mem #(
  parameter int ENTRIES = rbl_pkg::ENTRIES_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [rbl_pkg::REC_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output      logic [rbl_pkg::REC_W-1:0] rd_data
);

  logic [rbl_pkg::REC_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
module tb_top;

  localparam int RING_DEPTH     = rbl_pkg::ENTRIES_DEF;
  localparam int RANDOM_CMDS    = 825;
  localparam int DIRECTED_ROWS  = 25;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                         found;
    logic [rbl_pkg::SLOT_W-1:0]   slot;
    logic [rbl_pkg::HANDLE_W-1:0] hit_handle;
    logic [rbl_pkg::SIZE_W-1:0]   hit_size;
    logic [rbl_pkg::SIZE_W-1:0]   byte_in_rec;
    logic                         evicted;
    logic [rbl_pkg::HANDLE_W-1:0] ev_handle;
    logic [rbl_pkg::TOTAL_W-1:0]  total;
  } ring_result_t;

  typedef struct packed {
    logic                         op;
    logic [rbl_pkg::HANDLE_W-1:0] handle;
    logic [rbl_pkg::SIZE_W-1:0]   size;
    logic [rbl_pkg::OFFSET_W-1:0] offset;
    logic                         golden;
    ring_result_t                 res;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         op = rbl_pkg::OP_ADD;
  logic [rbl_pkg::HANDLE_W-1:0] record_handle = '0;
  logic [rbl_pkg::SIZE_W-1:0]   record_size = '0;
  logic [rbl_pkg::OFFSET_W-1:0] byte_offset = '0;
  logic                         busy;
  logic                         done;
  logic                         found;
  logic [rbl_pkg::SLOT_W-1:0]   slot_index;
  logic [rbl_pkg::HANDLE_W-1:0] hit_handle;
  logic [rbl_pkg::SIZE_W-1:0]   hit_size;
  logic [rbl_pkg::SIZE_W-1:0]   byte_in_record;
  logic                         evicted;
  logic [rbl_pkg::HANDLE_W-1:0] evicted_handle;
  logic [rbl_pkg::TOTAL_W-1:0]  total_bytes;

  logic                         use_golden = 1'b0;
  ring_result_t                 golden_res = '0;

  ring_buffer_byte_offset_lookup DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .record_handle  (record_handle),
    .record_size    (record_size),
    .byte_offset    (byte_offset),
    .done           (done),
    .found          (found),
    .slot_index     (slot_index),
    .hit_handle     (hit_handle),
    .hit_size       (hit_size),
    .byte_in_record (byte_in_record),
    .evicted        (evicted),
    .evicted_handle (evicted_handle),
    .total_bytes    (total_bytes)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ring model
  logic [rbl_pkg::HANDLE_W-1:0] ring_handles [RING_DEPTH];
  logic [rbl_pkg::SIZE_W-1:0]   ring_sizes [RING_DEPTH];
  int unsigned         ring_wr = 0;
  int unsigned         ring_rd = 0;
  int unsigned         ring_count = 0;
  bit                  ring_is_full = 1'b0;
  int unsigned         ring_total = 0;

  ring_result_t        pending_results [$];
  int                  mismatches = 0;
  int                  n_adds = 0;
  int                  n_lookups = 0;
  int                  n_hits = 0;
  int                  n_evictions = 0;
  int                  idle_cycles = 0;

  function automatic ring_result_t ring_apply(input logic cmd_op,
                                              input logic [rbl_pkg::HANDLE_W-1:0] h,
                                              input logic [rbl_pkg::SIZE_W-1:0] s,
                                              input logic [rbl_pkg::OFFSET_W-1:0] off);
    ring_result_t r;
    int unsigned  idx;
    int unsigned  sum;
    int unsigned  wp;
    int unsigned  n;
    int unsigned  rel;
    r = '0;
    if (cmd_op == rbl_pkg::OP_ADD) begin
      wp = ring_wr;
      if (ring_is_full) begin
        r.evicted   = 1'b1;
        r.ev_handle = ring_handles[wp];
        ring_total  = ring_total - ring_sizes[wp];
        ring_rd     = (ring_rd + 1) % RING_DEPTH;
      end
      ring_handles[wp] = h;
      ring_sizes[wp]   = s;
      ring_total       = ring_total + s;
      r.slot           = wp[rbl_pkg::SLOT_W-1:0];
      ring_wr          = (wp + 1) % RING_DEPTH;
      if (!ring_is_full) begin
        ring_count++;
        if (ring_count >= RING_DEPTH) ring_is_full = 1'b1;
      end
    end else begin
      idx = ring_rd;
      sum = 0;
      for (n = 0; n < ring_count; n++) begin
        if (sum + ring_sizes[idx] > off) begin
          rel           = off - sum;
          r.found       = 1'b1;
          r.slot        = idx[rbl_pkg::SLOT_W-1:0];
          r.hit_handle  = ring_handles[idx];
          r.hit_size    = ring_sizes[idx];
          r.byte_in_rec = rel[rbl_pkg::SIZE_W-1:0];
          break;
        end
        sum = sum + ring_sizes[idx];
        idx = (idx + 1) % RING_DEPTH;
      end
    end
    r.total = (ring_total > rbl_pkg::TOTAL_MAX) ? rbl_pkg::TOTAL_MAX :
              ring_total[rbl_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic ring_result_t outcome(input logic f,
                                           input logic [rbl_pkg::SLOT_W-1:0] sl,
                                           input logic [rbl_pkg::HANDLE_W-1:0] hh,
                                           input logic [rbl_pkg::SIZE_W-1:0] hs,
                                           input logic [rbl_pkg::SIZE_W-1:0] br,
                                           input logic ev,
                                           input logic [rbl_pkg::HANDLE_W-1:0] evh,
                                           input logic [rbl_pkg::TOTAL_W-1:0] tot);
    ring_result_t r;
    r.found = f; r.slot = sl; r.hit_handle = hh; r.hit_size = hs;
    r.byte_in_rec = br; r.evicted = ev; r.ev_handle = evh; r.total = tot;
    return r;
  endfunction

  function automatic stim_row_t cmd_row(input logic o,
                                        input logic [rbl_pkg::HANDLE_W-1:0] h,
                                        input logic [rbl_pkg::SIZE_W-1:0] s,
                                        input logic [rbl_pkg::OFFSET_W-1:0] off);
    stim_row_t row;
    row = '0;
    row.op = o; row.handle = h; row.size = s; row.offset = off;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic o,
                                            input logic [rbl_pkg::HANDLE_W-1:0] h,
                                            input logic [rbl_pkg::SIZE_W-1:0] s,
                                            input logic [rbl_pkg::OFFSET_W-1:0] off,
                                            input ring_result_t r);
    stim_row_t row;
    row = cmd_row(o, h, s, off);
    row.golden = 1'b1;
    row.res    = r;
    return row;
  endfunction

  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic issue_cmd(input stim_row_t row, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    op            <= row.op;
    record_handle <= row.handle;
    record_size   <= row.size;
    byte_offset   <= row.offset;
    use_golden    <= row.golden;
    golden_res    <= row.res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin : ring_monitor
    ring_result_t predicted;
    ring_result_t exp_res;
    if (!rst) begin
      if (start && !busy) begin
        predicted = ring_apply(op, record_handle, record_size, byte_offset);
        pending_results.push_back(use_golden ? golden_res : predicted);
        if (op == rbl_pkg::OP_ADD) n_adds++;
        else n_lookups++;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("found", 32'(exp_res.found), 32'(found));
          check_field("slot_index", 32'(exp_res.slot), 32'(slot_index));
          check_field("hit_handle", exp_res.hit_handle, hit_handle);
          check_field("hit_size", 32'(exp_res.hit_size), 32'(hit_size));
          check_field("byte_in_record", 32'(exp_res.byte_in_rec), 32'(byte_in_record));
          check_field("evicted", 32'(exp_res.evicted), 32'(evicted));
          check_field("evicted_handle", exp_res.ev_handle, evicted_handle);
          check_field("total_bytes", 32'(exp_res.total), 32'(total_bytes));
          if (found) n_hits++;
          if (evicted) n_evictions++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t           rows [DIRECTED_ROWS];
    stim_row_t           row;
    int                  i;
    int                  r;
    logic [31:0]         rnd;

    rows[0] = checked_row(rbl_pkg::OP_LOOKUP, '0, '0, '0, outcome(0, 0, 0, 0, 0, 0, 0, 0));
    rows[1] = checked_row(rbl_pkg::OP_LOOKUP, '0, '0, 20'hFFFFF,
                          outcome(0, 0, 0, 0, 0, 0, 0, 0));
    rows[2] = checked_row(rbl_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, '0,
                          outcome(0, 0, 0, 0, 0, 0, 0, 20'h0FFFF));
    rows[3] = checked_row(rbl_pkg::OP_ADD, 32'h0, 16'h0, 20'hFFFFF,
                          outcome(0, 1, 0, 0, 0, 0, 0, 20'h0FFFF));
    rows[4] = checked_row(rbl_pkg::OP_LOOKUP, '0, '0, '0,
                          outcome(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 20'h0FFFF));
    rows[5] = checked_row(rbl_pkg::OP_LOOKUP, '0, '0, 20'h0FFFE,
                          outcome(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, 0, 0, 20'h0FFFF));
    rows[6] = checked_row(rbl_pkg::OP_LOOKUP, '1, '1, 20'h0FFFF,
                          outcome(0, 0, 0, 0, 0, 0, 0, 20'h0FFFF));
    for (i = 7; i < 21; i++) begin
      rows[i] = cmd_row(rbl_pkg::OP_ADD, 32'h1000_0000 + i, 16'hFFFF, '0);
    end
    rows[21] = cmd_row(rbl_pkg::OP_LOOKUP, '0, '0, 20'hEFFF0);
    rows[22] = checked_row(rbl_pkg::OP_ADD, 32'hDEAD_BEEF, 16'h0001, '0,
                           outcome(0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 20'hDFFF3));
    rows[23] = cmd_row(rbl_pkg::OP_ADD, 32'h0000_0005, 16'h0007, '0);
    rows[24] = cmd_row(rbl_pkg::OP_LOOKUP, '0, '0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) issue_cmd(rows[i], pick_gap(1'b0));
    wait_drained();

    for (i = 0; i < RANDOM_CMDS; i++) begin
      row        = cmd_row(rbl_pkg::OP_ADD, $urandom, '0, '0);
      row.op     = ($urandom_range(0, 99) < 55) ? rbl_pkg::OP_LOOKUP : rbl_pkg::OP_ADD;
      r          = $urandom_range(0, 99);
      rnd        = $urandom;
      if (r < 10) row.size = '0;
      else if (r < 20) row.size = '1;
      else if (r < 60) row.size = rnd[rbl_pkg::SIZE_W-1:0];
      else row.size = rnd[5:0] + 16'd1;
      r = $urandom_range(0, 99);
      if (r < 60 && ring_total > 0) rnd = $urandom_range(0, ring_total - 1);
      else if (r < 70) rnd = ring_total;
      else if (r < 80 && ring_total > 0) rnd = ring_total - 1;
      else rnd = $urandom;
      row.offset = rnd[rbl_pkg::OFFSET_W-1:0];
      issue_cmd(row, pick_gap((i / 60) % 4 == 3));
      if (i % 200 == 199) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("tb: %0d adds and %0d lookups checked, %0d hits, %0d evictions",
             n_adds, n_lookups, n_hits, n_evictions);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
